>>> design/gdd_pkg.sv
// Shared types, constants and tables for the Gregorian date difference block.
// Used by the front, queue, back and top level files; depends on nothing.
package gdd_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int COUNT_W  = 22;
    localparam int Q100_W   = 7;
    localparam int DBM_W    = 9;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 24;

    localparam logic [YEAR_W-1:0]  YEAR_MIN   = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_MIN  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_MAX  = 4'd12;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [12:0]        DIV100_MUL = 13'd5243;
    localparam int                 DIV100_SHIFT = 19;
    localparam logic [8:0]         DAYS_PER_YEAR = 9'd365;
    localparam logic [6:0]         HUNDRED = 7'd100;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    typedef struct packed {
        date_t start_date;
        date_t end_date;
        logic  misordered;
    } request_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [YEAR_W-1:0]  prev_year;
        logic [Q100_W-1:0]  prev_q100;
        logic [Q100_W-1:0]  year_q100;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_split_t;

    function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] month);
        logic [DBM_W-1:0] days;
        case (month)
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

>>> design/gdd_front.sv
// Front end: unpacks a request, clamps years and months, flags reversed order.
// Depends on gdd_pkg.
module gdd_front (
    input  logic [gdd_pkg::IN_TDATA_W-1:0] tdata,
    output gdd_pkg::request_t              req
);

    function automatic gdd_pkg::date_t clamp_date(
        input logic [gdd_pkg::YEAR_W-1:0]  year,
        input logic [gdd_pkg::MONTH_W-1:0] month,
        input logic [gdd_pkg::DAY_W-1:0]   day
    );
        gdd_pkg::date_t d;
        if (year < gdd_pkg::YEAR_MIN)
            d.year = gdd_pkg::YEAR_MIN;
        else if (year > gdd_pkg::YEAR_MAX)
            d.year = gdd_pkg::YEAR_MAX;
        else
            d.year = year;
        if (month < gdd_pkg::MONTH_MIN)
            d.month = gdd_pkg::MONTH_MIN;
        else if (month > gdd_pkg::MONTH_MAX)
            d.month = gdd_pkg::MONTH_MAX;
        else
            d.month = month;
        d.day = day;
        return d;
    endfunction

    always_comb
    begin
        req.start_date = clamp_date(tdata[13:0], tdata[17:14], tdata[22:18]);
        req.end_date   = clamp_date(tdata[36:23], tdata[40:37], tdata[45:41]);
        req.misordered = req.end_date < req.start_date;
    end

endmodule

>>> design/gdd_queue.sv
// Four-entry request queue between the front end and the back end.
// Depends on gdd_pkg.
module gdd_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  gdd_pkg::request_t  push_req,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output gdd_pkg::request_t  head_req
);

    gdd_pkg::request_t             entry_reg [gdd_pkg::QUEUE_DEPTH];
    logic [gdd_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [gdd_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [gdd_pkg::QCNT_W-1:0]    count_reg, count_next;

    assign full       = count_reg == gdd_pkg::QCNT_W'(gdd_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_req   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + gdd_pkg::QCNT_W'(push) - gdd_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_req;
    end

endmodule

>>> design/gdd_back.sv
// Back end: three-stage pipeline from a clamped date pair to the day count.
// Depends on gdd_pkg.
module gdd_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             head_valid,
    input  gdd_pkg::request_t                head_req,
    output logic                             pop,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [gdd_pkg::COUNT_W-1:0]      out_count,
    output logic                             out_error
);

    function automatic logic [gdd_pkg::Q100_W-1:0] div100(input logic [gdd_pkg::YEAR_W-1:0] v);
        logic [26:0] prod;
        prod = 27'(v) * 27'(gdd_pkg::DIV100_MUL);
        return prod[gdd_pkg::DIV100_SHIFT +: gdd_pkg::Q100_W];
    endfunction

    function automatic gdd_pkg::date_split_t split_date(input gdd_pkg::date_t d);
        gdd_pkg::date_split_t s;
        s.year      = d.year;
        s.prev_year = d.year - 1'b1;
        s.prev_q100 = div100(d.year - 1'b1);
        s.year_q100 = div100(d.year);
        s.month     = d.month;
        s.day       = d.day;
        return s;
    endfunction

    function automatic logic [gdd_pkg::COUNT_W-1:0] serial_day(input gdd_pkg::date_split_t s);
        logic                         leap;
        logic [13:0]                  hundreds;
        logic [gdd_pkg::COUNT_W-1:0]  n;
        hundreds = 14'(s.year_q100) * 14'(gdd_pkg::HUNDRED);
        leap = (s.year[1:0] == 2'b00)
            && ((s.year != hundreds) || (s.year_q100[1:0] == 2'b00));
        n = gdd_pkg::COUNT_W'(s.prev_year) * gdd_pkg::COUNT_W'(gdd_pkg::DAYS_PER_YEAR)
            + gdd_pkg::COUNT_W'(s.prev_year[13:2])
            - gdd_pkg::COUNT_W'(s.prev_q100)
            + gdd_pkg::COUNT_W'(s.prev_q100[6:2])
            + gdd_pkg::COUNT_W'(gdd_pkg::days_before_month(s.month))
            + gdd_pkg::COUNT_W'(leap && (s.month > gdd_pkg::MONTH_FEB))
            + gdd_pkg::COUNT_W'(s.day);
        return n;
    endfunction

    logic                          advance;
    logic                          s1_valid_reg;
    gdd_pkg::date_split_t          s1_start_reg, s1_end_reg;
    logic                          s1_misordered_reg;
    logic                          s2_valid_reg;
    logic [gdd_pkg::COUNT_W-1:0]   s2_start_reg, s2_end_reg;
    logic                          s2_misordered_reg;
    logic                          out_valid_reg;
    logic [gdd_pkg::COUNT_W-1:0]   out_count_reg, out_count_next;
    logic                          out_error_reg, out_error_next;

    assign advance   = !out_valid_reg || out_ready;
    assign pop       = advance && head_valid;
    assign out_valid = out_valid_reg;
    assign out_count = out_count_reg;
    assign out_error = out_error_reg;

    always_comb
    begin
        out_error_next = s2_misordered_reg || (s2_end_reg < s2_start_reg);
        out_count_next = out_error_next ? '0 : s2_end_reg - s2_start_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= head_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_start_reg      <= split_date(head_req.start_date);
            s1_end_reg        <= split_date(head_req.end_date);
            s1_misordered_reg <= head_req.misordered;
            s2_start_reg      <= serial_day(s1_start_reg);
            s2_end_reg        <= serial_day(s1_end_reg);
            s2_misordered_reg <= s1_misordered_reg;
            out_count_reg     <= out_count_next;
            out_error_reg     <= out_error_next;
        end
    end

endmodule

>>> design/gregorian_date_difference.sv
// A request goes through a queue entry, stages s1 and s2 and the output register.
// Throughput: one request per cycle; a four-entry queue absorbs output stalls, and
// s_axis_tready falls only when that queue is full.
// Reset: asynchronous, active low; empties the queue and the pipeline, no clearing pass.
// Top level of the Gregorian date difference block; depends on gdd_pkg,
// gdd_front, gdd_queue and gdd_back.
module gregorian_date_difference (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // start_year, start_month, start_day, end_year, end_month, end_day, zero pad
    input  logic [gdd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // day_count, zero pad
    output logic [gdd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // order_error
    output logic                               m_axis_tuser
);

    gdd_pkg::request_t             front_req;
    gdd_pkg::request_t             head_req;
    logic                          queue_full;
    logic                          head_valid;
    logic                          pop;
    logic [gdd_pkg::COUNT_W-1:0]   day_count;

    assign s_axis_tready = !queue_full;
    assign m_axis_tdata  = gdd_pkg::OUT_TDATA_W'(day_count);

    gdd_front u_front (
        .tdata (s_axis_tdata),
        .req   (front_req)
    );

    gdd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s_axis_tvalid && !queue_full),
        .push_req   (front_req),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_req   (head_req)
    );

    gdd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_req   (head_req),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_count  (day_count),
        .out_error  (m_axis_tuser)
    );

endmodule

>>> design/gdd_checker.sv
// Port-level checker for the Gregorian date difference block, bound to the top level.
// Depends on gdd_pkg.
module gdd_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [gdd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                               m_axis_tuser
);

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("order error with non-zero day count");

    // a start day of 0 reaches one day further back than 1 January of year 1
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata <= gdd_pkg::OUT_TDATA_W'(3652059))
        else $error("day count beyond the year range");

endmodule

bind gregorian_date_difference gdd_checker u_gdd_checker (.*);

>>> sim/gregorian_date_difference_tb.sv
// Testbench for gregorian_date_difference: directed and random date pairs over the
// request stream, each result checked against a local day-number calculation.
// Depends on gdd_pkg and the gregorian_date_difference RTL.
module gregorian_date_difference_tb;
    import gdd_pkg::*;

    typedef struct packed {
        logic [COUNT_W-1:0] day_count;
        logic               order_error;
    } span_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    span_t span_q[$];
    int    errors = 0;
    int    results_seen = 0;
    bit    steady = 1'b0;

    gregorian_date_difference dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    function automatic int month_start(input int m);
        int days;
        case (m)
            1:       days = 0;
            2:       days = 31;
            3:       days = 59;
            4:       days = 90;
            5:       days = 120;
            6:       days = 151;
            7:       days = 181;
            8:       days = 212;
            9:       days = 243;
            10:      days = 273;
            11:      days = 304;
            default: days = 334;
        endcase
        return days;
    endfunction

    function automatic bit leap_year(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // day 1 is 1 January of year 1
    function automatic int day_number(input int y, input int m, input int d);
        int p;
        p = y - 1;
        return 365 * p + p / 4 - p / 100 + p / 400 + month_start(m)
               + ((m > 2 && leap_year(y)) ? 1 : 0) + d;
    endfunction

    function automatic int month_len(input int y, input int m);
        return (m == 12) ? 31 : day_number(y, m + 1, 1) - day_number(y, m, 1);
    endfunction

    function automatic span_t predict_span(
        input int sy,
        input int sm,
        input int sd,
        input int ey,
        input int em,
        input int ed
    );
        int    y1, m1, y2, m2, d1, d2, diff;
        bit    reversed;
        span_t s;
        y1 = (sy < YEAR_MIN) ? YEAR_MIN : (sy > YEAR_MAX) ? YEAR_MAX : sy;
        y2 = (ey < YEAR_MIN) ? YEAR_MIN : (ey > YEAR_MAX) ? YEAR_MAX : ey;
        m1 = (sm < MONTH_MIN) ? MONTH_MIN : (sm > MONTH_MAX) ? MONTH_MAX : sm;
        m2 = (em < MONTH_MIN) ? MONTH_MIN : (em > MONTH_MAX) ? MONTH_MAX : em;
        d1 = sd;
        d2 = ed;
        if (y2 != y1)
            reversed = y2 < y1;
        else if (m2 != m1)
            reversed = m2 < m1;
        else
            reversed = d2 < d1;
        diff = day_number(y2, m2, d2) - day_number(y1, m1, d1);
        if (reversed || diff < 0)
        begin
            s.day_count   = '0;
            s.order_error = 1'b1;
        end
        else
        begin
            s.day_count   = diff[COUNT_W-1:0];
            s.order_error = 1'b0;
        end
        return s;
    endfunction

    task automatic report_mismatch(input string what, input int want_v, input int got_v);
        $display("result %0d: %s expected %0d, got %0d", results_seen, what, want_v, got_v);
        errors++;
    endtask

    // hold the request until the handshake; tvalid stays high for a following request
    task automatic send_dates(
        input int sy,
        input int sm,
        input int sd,
        input int ey,
        input int em,
        input int ed
    );
        while (!steady && $urandom_range(99) < 22)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, DAY_W'(ed), MONTH_W'(em), YEAR_W'(ey),
                          DAY_W'(sd), MONTH_W'(sm), YEAR_W'(sy)};
        do
            @(negedge clk);
        while (!s_axis_tready);
        span_q.push_back(predict_span(sy, sm, sd, ey, em, ed));
        @(posedge clk);
    endtask

    task automatic rand_date(output int y, output int m, output int d);
        if ($urandom_range(9) < 3)
            y = $urandom_range(1, 99) * 100 + $urandom_range(0, 4) - 2;
        else
            y = $urandom_range(1, 9999);
        m = $urandom_range(1, 12);
        d = $urandom_range(1, month_len(y, m));
    endtask

    // mostly well-formed ordered pairs, some reversed, some raw field noise
    task automatic send_random_pair();
        int sy, sm, sd, ey, em, ed, kind, t;
        kind = $urandom_range(99);
        rand_date(sy, sm, sd);
        if (kind < 82)
        begin
            if (kind < 45)
                ey = sy + (($urandom_range(1) == 1) ? $urandom_range(0, 3)
                                                     : $urandom_range(0, 9999 - sy));
            else
                ey = sy;
            em = (kind < 60) ? $urandom_range(1, 12) : sm;
            if (ey == sy && em < sm && kind < 60)
            begin
                t = em; em = sm; sm = t;
                sd = $urandom_range(1, month_len(sy, sm));
            end
            ed = $urandom_range(1, month_len(ey, em));
            if (kind >= 70)
            begin
                t = sy; sy = ey; ey = t;
                t = sm; sm = em; em = t;
                t = sd; sd = ed; ed = t;
            end
            send_dates(sy, sm, sd, ey, em, ed);
        end
        else
            send_dates($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31),
                       $urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31));
    endtask

    task automatic test_directed();
        send_dates(2024, 2, 29, 2024, 2, 29);
        send_dates(1, 1, 1, 9999, 12, 31);
        send_dates(9999, 12, 31, 1, 1, 1);
        send_dates(0, 1, 1, 1, 1, 2);
        send_dates(16383, 1, 1, 9999, 1, 1);
        send_dates(2000, 0, 5, 2000, 1, 5);
        send_dates(2001, 15, 1, 2001, 12, 1);
        send_dates(2000, 3, 0, 2000, 3, 1);
        send_dates(2023, 2, 31, 2023, 3, 3);
        send_dates(2023, 2, 31, 2023, 3, 1);
        send_dates(1900, 2, 28, 1900, 3, 1);
        send_dates(2000, 2, 28, 2000, 3, 1);
        send_dates(2100, 2, 28, 2100, 3, 1);
        send_dates(2400, 2, 28, 2400, 3, 1);
        send_dates(2010, 6, 20, 2010, 6, 19);
        send_dates(2010, 6, 20, 2010, 5, 25);
        send_dates(9999, 1, 1, 9999, 12, 31);
        send_dates(0, 0, 0, 0, 0, 0);
        send_dates(16383, 15, 31, 16383, 15, 31);
        send_dates(0, 0, 0, 16383, 15, 31);
        send_dates(16383, 15, 31, 0, 0, 0);
        send_dates(1999, 12, 31, 2000, 1, 1);
    endtask

    task automatic test_random_mix(input int n);
        repeat (n) send_random_pair();
    endtask

    task automatic test_steady_stream(input int n);
        steady = 1'b1;
        repeat (n) send_random_pair();
        steady = 1'b0;
    endtask

    // drop tvalid and let the queue drain completely between bursts
    task automatic test_drain_pause(input int bursts);
        repeat (bursts)
        begin
            repeat ($urandom_range(5, 40)) send_random_pair();
            s_axis_tvalid <= 1'b0;
            while (span_q.size() != 0)
                @(posedge clk);
        end
    endtask

    always @(posedge clk)
        m_axis_tready <= steady || ($urandom_range(99) >= 22);

    always @(negedge clk)
    begin : result_check
        span_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (span_q.size() == 0)
                report_mismatch("unexpected result, day_count", -1,
                                int'(m_axis_tdata[COUNT_W-1:0]));
            else
            begin
                want = span_q.pop_front();
                if (m_axis_tdata[COUNT_W-1:0] !== want.day_count)
                    report_mismatch("day_count", int'(want.day_count),
                                    int'(m_axis_tdata[COUNT_W-1:0]));
                if (m_axis_tuser !== want.order_error)
                    report_mismatch("order_error", int'(want.order_error), int'(m_axis_tuser));
            end
        end
    end

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_mix(600);
        test_steady_stream(300);
        test_drain_pause(10);
        test_random_mix(30);
        s_axis_tvalid <= 1'b0;
        while (span_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("gregorian_date_difference verification clean");
        else
            $display("gregorian_date_difference verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("gregorian_date_difference verification failed");
        $finish;
    end

endmodule
